### sv/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants of the power mode sequencer
// Power state codes, event codes, message and vote codes, register map.
// ----------------------------------------------------------------------------
package pms_pkg;

  // one-hot power state
  typedef enum logic [7:0] {
    ST_NORMAL        = 8'b0000_0001,
    ST_SLEEP_CHECK   = 8'b0000_0010,
    ST_OFF_CHECK     = 8'b0000_0100,
    ST_EMERGENCY     = 8'b0000_1000,
    ST_ASLEEP        = 8'b0001_0000,
    ST_RESTART_APP   = 8'b0010_0000,
    ST_RESTART_MODEM = 8'b0100_0000,
    ST_UPDATE        = 8'b1000_0000
  } pms_state_e;

  // numeric state as reported on the result channel
  localparam logic [2:0] NUM_NORMAL        = 3'd0;
  localparam logic [2:0] NUM_SLEEP_CHECK   = 3'd1;
  localparam logic [2:0] NUM_OFF_CHECK     = 3'd2;
  localparam logic [2:0] NUM_EMERGENCY     = 3'd3;
  localparam logic [2:0] NUM_ASLEEP        = 3'd4;
  localparam logic [2:0] NUM_RESTART_APP   = 3'd5;
  localparam logic [2:0] NUM_RESTART_MODEM = 3'd6;
  localparam logic [2:0] NUM_UPDATE        = 3'd7;

  typedef enum logic [3:0] {
    EV_RING          = 4'd0,
    EV_RTC           = 4'd1,
    EV_RUNNING       = 4'd2,
    EV_TICK          = 4'd3,
    EV_EMERGENCY     = 4'd4,
    EV_OFF           = 4'd5,
    EV_SLEEP         = 4'd6,
    EV_RESTART_APP   = 4'd7,
    EV_RESTART_MODEM = 4'd8,
    EV_UPDATE        = 4'd9
  } pms_event_e;

  localparam logic [2:0] MSG_NONE      = 3'd0;
  localparam logic [2:0] MSG_RUNNING   = 3'd1;
  localparam logic [2:0] MSG_SLEEP     = 3'd2;
  localparam logic [2:0] MSG_OFF       = 3'd3;
  localparam logic [2:0] MSG_EMERGENCY = 3'd4;
  localparam logic [2:0] MSG_RTC       = 3'd5;

  localparam logic [1:0] VOTE_NONE   = 2'd0;
  localparam logic [1:0] VOTE_OPPOSE = 2'd1;
  localparam logic [1:0] VOTE_AGREE  = 2'd2;

  localparam logic [1:0] MARK_NONE  = 2'd0;
  localparam logic [1:0] MARK_AWAKE = 2'd1;
  localparam logic [1:0] MARK_SLEEP = 2'd2;

  localparam logic [1:0] UST_OK       = 2'd0;
  localparam logic [1:0] UST_PROGRESS = 2'd1;
  localparam logic [1:0] UST_ERROR    = 2'd2;

  localparam logic [1:0] MODE_RUNNING = 2'd0;
  localparam logic [1:0] MODE_DEEP    = 2'd2;
  localparam logic [1:0] MODE_OFF     = 2'd3;

  localparam logic [2:0] RESTART_WAIT_MAX = 3'd5;
  localparam logic [3:0] UPDATE_WAIT_MAX  = 4'd10;
  localparam logic [2:0] UPDATE_ERROR_MAX = 3'd3;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_SLEEP_MODE = 2'd0;
  localparam logic [1:0] REG_RTC_WAKEUP = 2'd1;
  localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;

  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd10;

  function automatic logic [2:0] state_num(pms_state_e st);
    logic [2:0] n;
    case (st)
      ST_NORMAL:        n = NUM_NORMAL;
      ST_SLEEP_CHECK:   n = NUM_SLEEP_CHECK;
      ST_OFF_CHECK:     n = NUM_OFF_CHECK;
      ST_EMERGENCY:     n = NUM_EMERGENCY;
      ST_ASLEEP:        n = NUM_ASLEEP;
      ST_RESTART_APP:   n = NUM_RESTART_APP;
      ST_RESTART_MODEM: n = NUM_RESTART_MODEM;
      ST_UPDATE:        n = NUM_UPDATE;
      default:          n = NUM_NORMAL;
    endcase
    return n;
  endfunction

endpackage

### sv/power_mode_sequencer.sv
// ----------------------------------------------------------------------------
// power_mode_sequencer: eight-state power-mode controller
// One event item in, one result item out: new state plus action strobes.
// ----------------------------------------------------------------------------
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-------------------------------------
// event in | event_valid_i/_ready_o    | event_req, usb_hold, mcu_hold,
//          |                           | modules_ready, socket_data, update_status
// result   | result_valid_o/_ready_i   | state_now .. app_sleep_mark
// config   | APB psel/penable/pwrite   | sleep_mode, rtc_wakeup_seconds,
//          |                           | idle_ticks_limit
//
// One item per cycle while results are taken: the next-state decision is one
// pass of logic from the accepted item and the state registers into the result
// register, read out the cycle after acceptance. A stalled result holds there;
// a new item is taken in the same cycle the held result leaves.
// Reset: normal state, counters zero, idle limit 10, no result pending.
// ----------------------------------------------------------------------------
module power_mode_sequencer
  import pms_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        event_valid_i,
  output logic        event_ready_o,
  input  logic [3:0]  event_req_i,
  input  logic        usb_hold_i,
  input  logic        mcu_hold_i,
  input  logic        modules_ready_i,
  input  logic        socket_data_i,
  input  logic [1:0]  update_status_i,

  output logic        result_valid_o,
  input  logic        result_ready_i,
  output logic [2:0]  state_now_o,
  output logic [2:0]  notify_msg_o,
  output logic [1:0]  vote_action_o,
  output logic        wake_line_o,
  output logic        arm_rtc_timer_o,
  output logic        power_down_o,
  output logic        kill_app_o,
  output logic        start_update_o,
  output logic        abandon_update_o,
  output logic [1:0]  app_sleep_mark_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [1:0]  sleep_mode_q;
  logic [15:0] rtc_seconds_q;
  logic [7:0]  idle_limit_q;
  logic        cfg_wr;

  // sequencer state
  pms_state_e state_q, state_d;
  logic       wake_q, wake_d;
  logic [7:0] idle_q, idle_d;
  logic [2:0] app_wait_q, app_wait_d;
  logic [2:0] mdm_wait_q, mdm_wait_d;
  logic [3:0] upd_wait_q, upd_wait_d;
  logic [2:0] upd_err_q, upd_err_d;

  // result register
  logic       out_valid_q;
  logic [2:0] msg_d, msg_q;
  logic [1:0] vote_d, vote_q;
  logic [1:0] mark_d, mark_q;
  logic       arm_d, arm_q;
  logic       pdown_d, pdown_q;
  logic       kill_d, kill_q;
  logic       start_d, start_q;
  logic       abandon_d, abandon_q;
  logic [2:0] snum_q;
  logic       wline_q;

  logic       accept;
  logic       hold;
  logic       off_hold;
  logic       allow;
  logic [7:0] idle_inc;
  logic [3:0] upd_wait_inc;
  logic [2:0] upd_err_inc;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_mode_q  <= '0;
      rtc_seconds_q <= '0;
      idle_limit_q  <= IDLE_LIMIT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_SLEEP_MODE: sleep_mode_q  <= pwdata[1:0];
        REG_RTC_WAKEUP: rtc_seconds_q <= pwdata[15:0];
        REG_IDLE_LIMIT: idle_limit_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SLEEP_MODE: prdata = {30'd0, sleep_mode_q};
      REG_RTC_WAKEUP: prdata = {16'd0, rtc_seconds_q};
      REG_IDLE_LIMIT: prdata = {24'd0, idle_limit_q};
      default:        prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- handshake
  assign event_ready_o = !out_valid_q || result_ready_i;
  assign accept        = event_valid_i && event_ready_o;

  // ------------------------------------------------------- next-state pass
  assign hold         = usb_hold_i || mcu_hold_i;
  assign off_hold     = mcu_hold_i || (usb_hold_i && (sleep_mode_q < MODE_DEEP));
  assign idle_inc     = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
  assign upd_wait_inc = (upd_wait_q == 4'hF) ? upd_wait_q : upd_wait_q + 4'd1;
  assign upd_err_inc  = (upd_err_q == 3'h7) ? upd_err_q : upd_err_q + 3'd1;

  always_comb begin
    state_d    = state_q;
    wake_d     = wake_q;
    idle_d     = idle_q;
    app_wait_d = app_wait_q;
    mdm_wait_d = mdm_wait_q;
    upd_wait_d = upd_wait_q;
    upd_err_d  = upd_err_q;
    msg_d      = MSG_NONE;
    vote_d     = VOTE_NONE;
    mark_d     = MARK_NONE;
    arm_d      = 1'b0;
    pdown_d    = 1'b0;
    kill_d     = 1'b0;
    start_d    = 1'b0;
    abandon_d  = 1'b0;
    allow      = modules_ready_i;

    case (pms_event_e'(event_req_i))
      EV_RING: begin
        if (state_q == ST_NORMAL) begin
          if (!mcu_hold_i) wake_d = 1'b1;
        end else if (state_q == ST_SLEEP_CHECK || state_q == ST_OFF_CHECK ||
                     state_q == ST_ASLEEP) begin
          vote_d  = VOTE_OPPOSE;
          state_d = ST_NORMAL;
          msg_d   = MSG_RUNNING;
          wake_d  = 1'b1;
        end
      end
      EV_RTC: begin
        if (state_q == ST_SLEEP_CHECK || state_q == ST_ASLEEP) begin
          vote_d  = VOTE_OPPOSE;
          msg_d   = MSG_RTC;
          state_d = ST_SLEEP_CHECK;
        end
      end
      EV_RUNNING: begin
        if (state_q == ST_SLEEP_CHECK || state_q == ST_OFF_CHECK ||
            state_q == ST_EMERGENCY) begin
          vote_d  = VOTE_OPPOSE;
          state_d = ST_NORMAL;
          msg_d   = MSG_RUNNING;
          mark_d  = MARK_AWAKE;
        end
      end
      EV_TICK: begin
        case (state_q)
          ST_NORMAL: begin
            if (hold) begin
              idle_d = '0;
              wake_d = 1'b0;
            end else if (idle_inc >= idle_limit_q) begin
              idle_d = '0;
              if (sleep_mode_q != MODE_RUNNING) begin
                state_d = ST_OFF_CHECK;
                msg_d   = MSG_OFF;
              end else begin
                state_d = ST_SLEEP_CHECK;
                msg_d   = MSG_SLEEP;
              end
            end else begin
              idle_d = idle_inc;
            end
          end
          ST_SLEEP_CHECK: begin
            if (hold) begin
              vote_d  = VOTE_OPPOSE;
              state_d = ST_NORMAL;
              msg_d   = MSG_RUNNING;
              mark_d  = MARK_AWAKE;
              wake_d  = 1'b0;
            end else if (modules_ready_i && !wake_q) begin
              state_d = ST_ASLEEP;
              arm_d   = (rtc_seconds_q != 16'd0);
              vote_d  = VOTE_AGREE;
            end
          end
          ST_OFF_CHECK: begin
            if (off_hold) begin
              vote_d  = VOTE_OPPOSE;
              state_d = ST_NORMAL;
              msg_d   = MSG_RUNNING;
              mark_d  = MARK_AWAKE;
              wake_d  = 1'b0;
            end else if (modules_ready_i && !wake_q) begin
              pdown_d = 1'b1;
            end
          end
          ST_EMERGENCY: begin
            wake_d = 1'b0;
            if (modules_ready_i) mark_d = MARK_SLEEP;
          end
          ST_ASLEEP: begin
            if (hold) begin
              vote_d  = VOTE_OPPOSE;
              state_d = ST_NORMAL;
              msg_d   = MSG_RUNNING;
              mark_d  = MARK_AWAKE;
              wake_d  = 1'b0;
            end else if (socket_data_i) begin
              vote_d  = VOTE_OPPOSE;
              state_d = ST_NORMAL;
              msg_d   = MSG_RUNNING;
              wake_d  = 1'b1;
            end
          end
          ST_RESTART_APP: begin
            if (modules_ready_i || app_wait_q > RESTART_WAIT_MAX) kill_d = 1'b1;
            else if (app_wait_q != 3'h7) app_wait_d = app_wait_q + 3'd1;
          end
          ST_RESTART_MODEM: begin
            if (modules_ready_i || mdm_wait_q > RESTART_WAIT_MAX) pdown_d = 1'b1;
            else if (mdm_wait_q != 3'h7) mdm_wait_d = mdm_wait_q + 3'd1;
          end
          ST_UPDATE: begin
            if (!modules_ready_i) begin
              upd_wait_d = upd_wait_inc;
              if (upd_wait_inc > UPDATE_WAIT_MAX) allow = 1'b1;
            end
            if (update_status_i == UST_ERROR) begin
              if (upd_err_inc > UPDATE_ERROR_MAX) begin
                // fourth error gives up on the update
                abandon_d = 1'b1;
                upd_err_d = '0;
                state_d   = ST_NORMAL;
                msg_d     = MSG_RUNNING;
              end else begin
                upd_err_d = upd_err_inc;
                start_d   = allow;
              end
            end else if (update_status_i != UST_OK && update_status_i != UST_PROGRESS) begin
              start_d = allow;
            end
          end
          default: ;
        endcase
      end
      EV_EMERGENCY: begin
        if (state_q == ST_NORMAL || state_q == ST_SLEEP_CHECK) begin
          state_d = ST_EMERGENCY;
          msg_d   = MSG_EMERGENCY;
        end
      end
      EV_OFF: begin
        if (state_q == ST_NORMAL || state_q == ST_EMERGENCY) begin
          state_d = ST_OFF_CHECK;
          msg_d   = MSG_OFF;
        end
      end
      EV_SLEEP: begin
        if (state_q == ST_NORMAL) begin
          state_d = ST_SLEEP_CHECK;
          msg_d   = MSG_SLEEP;
        end
      end
      EV_RESTART_APP: begin
        if (state_q == ST_NORMAL) begin
          state_d = ST_RESTART_APP;
          msg_d   = MSG_OFF;
        end
      end
      EV_RESTART_MODEM: begin
        if (state_q == ST_NORMAL) begin
          state_d = ST_RESTART_MODEM;
          msg_d   = MSG_OFF;
        end
      end
      EV_UPDATE: begin
        if (state_q == ST_NORMAL) begin
          state_d = ST_UPDATE;
          msg_d   = MSG_OFF;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_NORMAL;
      wake_q     <= 1'b0;
      idle_q     <= '0;
      app_wait_q <= '0;
      mdm_wait_q <= '0;
      upd_wait_q <= '0;
      upd_err_q  <= '0;
    end else if (accept) begin
      state_q    <= state_d;
      wake_q     <= wake_d;
      idle_q     <= idle_d;
      app_wait_q <= app_wait_d;
      mdm_wait_q <= mdm_wait_d;
      upd_wait_q <= upd_wait_d;
      upd_err_q  <= upd_err_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (event_ready_o) begin
      out_valid_q <= event_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      snum_q    <= state_num(state_d);
      msg_q     <= msg_d;
      vote_q    <= vote_d;
      wline_q   <= wake_d;
      arm_q     <= arm_d;
      pdown_q   <= pdown_d;
      kill_q    <= kill_d;
      start_q   <= start_d;
      abandon_q <= abandon_d;
      mark_q    <= mark_d;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign state_now_o      = snum_q;
  assign notify_msg_o     = msg_q;
  assign vote_action_o    = vote_q;
  assign wake_line_o      = wline_q;
  assign arm_rtc_timer_o  = arm_q;
  assign power_down_o     = pdown_q;
  assign kill_app_o       = kill_q;
  assign start_update_o   = start_q;
  assign abandon_update_o = abandon_q;
  assign app_sleep_mark_o = mark_q;

endmodule
